FILE: rtl/core/ebce_pkg.sv
// Shared types and constants of the 8-bit core execute block.
package ebce_pkg;

	typedef enum logic [3:0] {
		OP_NONE = 4'd0,
		OP_ADD  = 4'd1,
		OP_SUB  = 4'd2,
		OP_MUL  = 4'd3,
		OP_MOVI = 4'd4,
		OP_BEQZ = 4'd5,
		OP_ANDI = 4'd6,
		OP_EOR  = 4'd7,
		OP_BR   = 4'd8,
		OP_SAL  = 4'd9,
		OP_SAR  = 4'd10,
		OP_LDR  = 4'd11,
		OP_STR  = 4'd12
	} op_t;

	localparam int unsigned FLAG_C = 4;
	localparam int unsigned FLAG_V = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_S = 1;
	localparam int unsigned FLAG_Z = 0;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		op_t         op;
		logic [5:0]  r1;
		logic [5:0]  r2;
		logic [15:0] addr;
		logic        wr_reg;
		logic        wr_mem;
	} instr_t;

	typedef struct packed {
		logic   valid;
		instr_t ins;
	} issue_t;

	typedef struct packed {
		logic [4:0]         status_flags;
		logic               reg_written;
		logic [5:0]         reg_index;
		logic signed [7:0]  reg_value;
		logic               mem_written;
		logic [5:0]         mem_address;
		logic               branch_taken;
		logic [15:0]        branch_target;
	} result_t;

endpackage

FILE: rtl/core/ebce_fifo.sv
// Two-entry word queue used between the front, the back and the result ports.
module ebce_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	logic [WIDTH-1:0] slot_q [ebce_pkg::QUEUE_DEPTH];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == 2'(ebce_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == 2'd0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign dout    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_q <= ~wr_q;
			end
			if (pop_ok) begin
				rd_q <= ~rd_q;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 2'd1;
			end else if (!push_ok && pop_ok) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(ebce_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'(ebce_pkg::QUEUE_DEPTH)) |-> (wr_q == rd_q))
		else $error("queue pointers disagree with count");
endmodule

FILE: rtl/core/ebce_front.sv
// Front part: accepts instruction words, classifies them and queues them.
module ebce_front #(
	parameter int REG_COUNT  = 64,
	parameter int DATA_WORDS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [15:0]           instruction_word,
	input  logic [15:0]           instruction_address,
	output ebce_pkg::issue_t      head,
	input  logic                  head_pop
);
	localparam logic [6:0]  REG_LIMIT = 7'(REG_COUNT);
	localparam logic [11:0] DS_LIMIT  = 12'(DATA_WORDS);

	ebce_pkg::instr_t dec;
	logic             empty;
	logic [$bits(ebce_pkg::instr_t)-1:0] head_bits;

	always_comb begin
		dec.r1   = instruction_word[11:6];
		dec.r2   = instruction_word[5:0];
		dec.addr = instruction_address;
		if (instruction_word[15:12] >= 4'(ebce_pkg::OP_ADD) &&
				instruction_word[15:12] <= 4'(ebce_pkg::OP_STR)) begin
			dec.op = ebce_pkg::op_t'(instruction_word[15:12]);
		end else begin
			dec.op = ebce_pkg::OP_NONE;
		end
		unique case (dec.op)
			ebce_pkg::OP_ADD, ebce_pkg::OP_SUB, ebce_pkg::OP_MUL, ebce_pkg::OP_MOVI,
			ebce_pkg::OP_ANDI, ebce_pkg::OP_EOR, ebce_pkg::OP_SAL, ebce_pkg::OP_SAR,
			ebce_pkg::OP_LDR: dec.wr_reg = ({1'b0, dec.r1} < REG_LIMIT);
			default:          dec.wr_reg = 1'b0;
		endcase
		dec.wr_mem = (dec.op == ebce_pkg::OP_STR) && ({6'b0, dec.r2} < DS_LIMIT);
	end

	ebce_fifo #(
		.WIDTH($bits(ebce_pkg::instr_t))
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (dec),
		.full  (full),
		.pop   (head_pop),
		.dout  (head_bits),
		.empty (empty)
	);

	assign head.valid = !empty;
	assign head.ins   = head_bits;
endmodule

FILE: rtl/core/ebce_back.sv
// Back part: register file, data store, execute stage and result queue.
module ebce_back #(
	parameter int REG_COUNT  = 64,
	parameter int DATA_WORDS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ebce_pkg::issue_t  head,
	output logic              head_pop,
	input  logic              pop,
	output logic              empty,
	output ebce_pkg::result_t res_out
);
	localparam int RIDX_W   = $clog2(REG_COUNT);
	localparam int DS_DEPTH = (DATA_WORDS < 64) ? DATA_WORDS : 64;
	localparam int DIDX_W   = $clog2(DS_DEPTH);
	localparam logic [6:0]  REG_LIMIT = 7'(REG_COUNT);
	localparam logic [11:0] DS_LIMIT  = 12'(DATA_WORDS);

	logic [7:0] rf_mem [REG_COUNT];
	logic [7:0] ds_mem [DS_DEPTH];
	logic [REG_COUNT-1:0] rf_valid_q;
	logic [DS_DEPTH-1:0]  ds_valid_q;

	logic             valid_s2;
	ebce_pkg::instr_t ins_s2;
	logic [7:0]       a_raw_s2, b_raw_s2, ld_raw_s2;
	logic             a_ok_s2, b_ok_s2, ld_ok_s2;
	logic             fwd_a_s2, fwd_b_s2, fwd_ld_s2;
	logic [7:0]       fwd_val_s2;

	logic              commit;
	logic              advance;
	logic              oq_full;
	logic [7:0]        a, b, ld, val;
	logic [8:0]        sum9;
	logic [2:0]        sh;
	logic [15:0]       mul16;
	ebce_pkg::result_t res;
	logic [$bits(ebce_pkg::result_t)-1:0] oq_bits;
	logic              head_r1_ok, head_r2_ok, head_ds_ok;

	assign commit   = valid_s2 && !oq_full;
	assign advance  = !valid_s2 || commit;
	assign head_pop = head.valid && advance;

	assign head_r1_ok = ({1'b0, head.ins.r1} < REG_LIMIT);
	assign head_r2_ok = ({1'b0, head.ins.r2} < REG_LIMIT);
	assign head_ds_ok = ({6'b0, head.ins.r2} < DS_LIMIT);

	// Memory ports: synchronous write at commit, registered read at issue.
	always_ff @(posedge clk) begin
		if (commit && res.reg_written) begin
			rf_mem[ins_s2.r1[RIDX_W-1:0]] <= res.reg_value;
		end
		if (commit && res.mem_written) begin
			ds_mem[ins_s2.r2[DIDX_W-1:0]] <= a;
		end
		if (head_pop) begin
			a_raw_s2  <= rf_mem[head.ins.r1[RIDX_W-1:0]];
			b_raw_s2  <= rf_mem[head.ins.r2[RIDX_W-1:0]];
			ld_raw_s2 <= ds_mem[head.ins.r2[DIDX_W-1:0]];
		end
	end

	// The read above returns the old word when the same entry is written at
	// that edge, so the committing result is captured alongside for bypass.
	always_ff @(posedge clk) begin
		if (head_pop) begin
			ins_s2     <= head.ins;
			a_ok_s2    <= head_r1_ok && rf_valid_q[head.ins.r1[RIDX_W-1:0]];
			b_ok_s2    <= head_r2_ok && rf_valid_q[head.ins.r2[RIDX_W-1:0]];
			ld_ok_s2   <= head_ds_ok && ds_valid_q[head.ins.r2[DIDX_W-1:0]];
			fwd_a_s2   <= commit && res.reg_written && (res.reg_index == head.ins.r1);
			fwd_b_s2   <= commit && res.reg_written && (res.reg_index == head.ins.r2);
			fwd_ld_s2  <= commit && res.mem_written && (res.mem_address == head.ins.r2);
			fwd_val_s2 <= res.mem_written ? a : res.reg_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			rf_valid_q <= '0;
			ds_valid_q <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= head.valid;
			end
			if (commit && res.reg_written) begin
				rf_valid_q[ins_s2.r1[RIDX_W-1:0]] <= 1'b1;
			end
			if (commit && res.mem_written) begin
				ds_valid_q[ins_s2.r2[DIDX_W-1:0]] <= 1'b1;
			end
		end
	end

	assign a  = fwd_a_s2  ? fwd_val_s2 : (a_ok_s2  ? a_raw_s2  : 8'd0);
	assign b  = fwd_b_s2  ? fwd_val_s2 : (b_ok_s2  ? b_raw_s2  : 8'd0);
	assign ld = fwd_ld_s2 ? fwd_val_s2 : (ld_ok_s2 ? ld_raw_s2 : 8'd0);

	always_comb begin
		sum9  = 9'd0;
		sh    = 3'd0;
		mul16 = a * b;
		val   = 8'd0;
		res   = '0;
		unique case (ins_s2.op)
			ebce_pkg::OP_ADD: begin
				sum9 = {1'b0, a} + {1'b0, b};
				val  = sum9[7:0];
				res.status_flags[ebce_pkg::FLAG_C] = sum9[8];
				res.status_flags[ebce_pkg::FLAG_V] = ~(a[7] ^ b[7]) & (a[7] ^ val[7]);
			end
			ebce_pkg::OP_SUB: begin
				val = a - b;
				res.status_flags[ebce_pkg::FLAG_V] = (a[7] ^ b[7]) & (a[7] ^ val[7]);
			end
			ebce_pkg::OP_MUL:  val = mul16[7:0];
			ebce_pkg::OP_MOVI: val = {2'b00, ins_s2.r2};
			ebce_pkg::OP_BEQZ: begin
				if (a == 8'd0) begin
					res.branch_taken  = 1'b1;
					res.branch_target = ins_s2.addr + 16'd1 + {10'd0, ins_s2.r2};
				end
			end
			ebce_pkg::OP_ANDI: val = a & {2'b00, ins_s2.r2};
			ebce_pkg::OP_EOR:  val = a ^ b;
			ebce_pkg::OP_BR: begin
				res.branch_taken  = 1'b1;
				res.branch_target = {a, b};
			end
			ebce_pkg::OP_SAL: begin
				val = (ins_s2.r2 >= 6'd8) ? 8'd0 : (a << ins_s2.r2[2:0]);
			end
			ebce_pkg::OP_SAR: begin
				sh  = (ins_s2.r2 >= 6'd8) ? 3'd7 : ins_s2.r2[2:0];
				val = 8'($signed(a) >>> sh);
			end
			ebce_pkg::OP_LDR:  val = ld;
			ebce_pkg::OP_STR:  res.mem_written = ins_s2.wr_mem;
			ebce_pkg::OP_NONE: val = 8'd0;
			default:           val = 8'd0;
		endcase
		unique case (ins_s2.op)
			ebce_pkg::OP_ADD, ebce_pkg::OP_SUB: begin
				res.status_flags[ebce_pkg::FLAG_N] = val[7];
				res.status_flags[ebce_pkg::FLAG_Z] = (val == 8'd0);
				res.status_flags[ebce_pkg::FLAG_S] = val[7] ^ res.status_flags[ebce_pkg::FLAG_V];
			end
			ebce_pkg::OP_MUL, ebce_pkg::OP_ANDI, ebce_pkg::OP_EOR, ebce_pkg::OP_SAL,
			ebce_pkg::OP_SAR: begin
				res.status_flags[ebce_pkg::FLAG_N] = val[7];
				res.status_flags[ebce_pkg::FLAG_Z] = (val == 8'd0);
			end
			default: res.status_flags = res.status_flags;
		endcase
		if (ins_s2.wr_reg) begin
			res.reg_written = 1'b1;
			res.reg_index   = ins_s2.r1;
			res.reg_value   = val;
		end
		if (res.mem_written) begin
			res.mem_address = ins_s2.r2;
		end
	end

	ebce_fifo #(
		.WIDTH($bits(ebce_pkg::result_t))
	) u_result_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (commit),
		.din   (res),
		.full  (oq_full),
		.pop   (pop),
		.dout  (oq_bits),
		.empty (empty)
	);

	assign res_out = oq_bits;

	a_commit_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> valid_s2)
		else $error("commit without a word in execute");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && oq_full) |=> (valid_s2 && $stable(ins_s2)))
		else $error("execute word changed while stalled");

	a_no_double_write: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !(res.reg_written && res.mem_written))
		else $error("one word wrote both register file and data store");

	a_issue_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> head.valid)
		else $error("issue from an empty queue");
endmodule

FILE: rtl/core/eight_bit_core_execute.sv
// Top level of the 8-bit core execute block: front queue feeding the execute back end.
// Path: input queue, then the execute stage register, then the result queue.
// Throughput: one word per cycle, set by the single execute stage and one register file
// write port; a full result queue stalls execute, and a full input queue raises full.
// Reset: queues and the execute stage empty at once; register file and data store read
// as zero through per-entry valid bits cleared by reset, with no clearing pass.
module eight_bit_core_execute #(
	parameter int REG_COUNT  = 64,
	parameter int DATA_WORDS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [15:0]        instruction_word,
	input  logic [15:0]        instruction_address,
	output logic               empty,
	input  logic               pop,
	output logic [4:0]         status_flags,
	output logic               reg_written,
	output logic [5:0]         reg_index,
	output logic signed [7:0]  reg_value,
	output logic               mem_written,
	output logic [5:0]         mem_address,
	output logic               branch_taken,
	output logic [15:0]        branch_target
);
	ebce_pkg::issue_t  head;
	logic              head_pop;
	ebce_pkg::result_t res;

	ebce_front #(
		.REG_COUNT (REG_COUNT),
		.DATA_WORDS(DATA_WORDS)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.instruction_word   (instruction_word),
		.instruction_address(instruction_address),
		.head               (head),
		.head_pop           (head_pop)
	);

	ebce_back #(
		.REG_COUNT (REG_COUNT),
		.DATA_WORDS(DATA_WORDS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.head_pop(head_pop),
		.pop     (pop),
		.empty   (empty),
		.res_out (res)
	);

	assign status_flags  = res.status_flags;
	assign reg_written   = res.reg_written;
	assign reg_index     = res.reg_index;
	assign reg_value     = res.reg_value;
	assign mem_written   = res.mem_written;
	assign mem_address   = res.mem_address;
	assign branch_taken  = res.branch_taken;
	assign branch_target = res.branch_target;
endmodule
